/* rtl/core/roulette_next_node_selector_macros.svh */
// Assertion helpers for the next-node selector.
`ifndef ROULETTE_NEXT_NODE_SELECTOR_MACROS_SVH
`define ROULETTE_NEXT_NODE_SELECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define RNS_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("selector check failed");
// Next-cycle implication, disabled in reset.
`define RNS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("selector check failed");
`else
`define RNS_ASSERT_NOW(lbl, a, c)
`define RNS_ASSERT_NEXT(lbl, a, c)
`endif

`endif

/* rtl/core/rns_pkg.sv */
package rns_pkg;

  localparam int MAX_NODES  = 127;
  localparam int CAND_SLOTS = 16;

  localparam int ACTION_W = 2;
  localparam int ROW_W    = 7;
  localparam int SLOT_W   = 4;
  localparam int NODE_W   = 7;
  localparam int VAL_W    = 32;
  localparam int IN_W     = 120;
  localparam int OUT_W    = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_CAND = 2'd0,
    ACT_LOAD_DIST = 2'd1,
    ACT_START     = 2'd2,
    ACT_SELECT    = 2'd3
  } action_t;

  typedef enum logic {
    REG_NODE_COUNT = 1'b0,
    REG_CAND_USE   = 1'b1
  } reg_idx_t;

endpackage

/* rtl/core/roulette_next_node_selector.sv */
// Select: a weight-sum pass over k candidate slots, a threshold step, a pick pass, a mark;
// on a zero weight sum the nearest-node scan over n nodes replaces the pick, and the mark
// is skipped if none is left. Start: result follows the visited-map clearing sweep.
// Loads: result issued straight from the finish state. The next word is taken in the cycle
// after the result is issued, later while a finished result waits in the output register.
// Reset (rst_n low, synchronous) clears control state, then sweeps the visited map
// before the first word is taken.
`include "roulette_next_node_selector_macros.svh"

module roulette_next_node_selector
  import rns_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // row[6:0], slot[10:7], node[17:11], score[49:18], distance[81:50], seed[113:82]
  input  logic [IN_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0] in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // next_node[6:0]
  output logic [OUT_W-1:0] out_tdata,
  // used_fallback[0]
  output logic             out_tuser,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [6:0]       cfg_wdata
);

  localparam int ROWS = MAX_NODES + 1;
  localparam int RW   = $clog2(ROWS);
  localparam int CA   = $clog2(ROWS * CAND_SLOTS) < 1 ? 1 : $clog2(ROWS * CAND_SLOTS);
  localparam int DA   = $clog2(ROWS * ROWS);
  localparam int KW   = $clog2(CAND_SLOTS + 1);
  localparam int SW   = VAL_W + KW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SUM, ST_THR1, ST_THR2, ST_PICK, ST_FALL, ST_MARK, ST_FIN
  } state_t;

  state_t state_r;

  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [NODE_W-1:0] in_node;
  logic [VAL_W-1:0]  in_score, in_dist, in_seed;
  logic              in_acc;

  assign in_row   = in_tdata[6:0];
  assign in_slot  = in_tdata[10:7];
  assign in_node  = in_tdata[17:11];
  assign in_score = in_tdata[49:18];
  assign in_dist  = in_tdata[81:50];
  assign in_seed  = in_tdata[113:82];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  logic [NODE_W-1:0] node_count_r;
  logic [4:0]        cand_use_r;
  logic [NODE_W-1:0] n_eff;
  logic [KW-1:0]     k_eff;

  always_comb begin
    if (node_count_r == '0) n_eff = NODE_W'(1);
    else if (32'(node_count_r) > MAX_NODES) n_eff = NODE_W'(MAX_NODES);
    else n_eff = node_count_r;
    if (cand_use_r == '0) k_eff = KW'(1);
    else if (32'(cand_use_r) > CAND_SLOTS) k_eff = KW'(CAND_SLOTS);
    else k_eff = KW'(cand_use_r);
  end

  // memories
  logic [NODE_W+VAL_W-1:0] cand_mem [ROWS*CAND_SLOTS];
  logic [VAL_W-1:0]        dist_mem [ROWS*ROWS];
  logic                    vis_mem  [ROWS];

  logic                    cand_we, dist_we, vis_we, vis_wd;
  logic [CA-1:0]           cand_wa, cand_ra;
  logic [DA-1:0]           dist_wa, dist_ra;
  logic [RW-1:0]           vis_wa, vis_ra;
  logic [NODE_W+VAL_W-1:0] cand_q;
  logic [VAL_W-1:0]        dist_q;
  logic                    vis_q;

  always_ff @(posedge clk) begin
    if (cand_we) cand_mem[cand_wa] <= {in_node, in_score};
    cand_q <= cand_mem[cand_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= in_dist;
    dist_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  // datapath registers
  logic [RW-1:0]     clr_r;
  logic              is_start_r;
  logic [VAL_W-1:0]  rs_r, rs_nxt, rs_x;
  logic [CA-1:0]     base_r;
  logic [DA-1:0]     dbase_r;
  logic [KW-1:0]     iss_r;
  logic              p1_r, p2_r;
  logic [NODE_W-1:0] p2_node_r;
  logic [VAL_W-1:0]  p2_w_r;
  logic [SW-1:0]     sum_r, run_r, thr_r, run_nxt;
  logic [63:0]       prod_lo_r;
  logic [SW-1:0]     prod_hi_r;
  logic              found_r;
  logic [NODE_W-1:0] last_r, chosen_r;
  logic              fell_r;
  logic [NODE_W:0]   v_r;
  logic              fv_r;
  logic [NODE_W-1:0] fv_node_r;
  logic [VAL_W-1:0]  best_r;
  logic              out_valid_r, out_fb_r;
  logic [NODE_W-1:0] out_node_r;

  logic issue, elig, f_issue, f_take;

  assign issue   = (iss_r < k_eff);
  assign elig    = p2_r && (p2_node_r != '0) && (p2_node_r <= n_eff) && !vis_q;
  assign run_nxt = run_r + SW'(p2_w_r);
  assign f_issue = (v_r <= {1'b0, n_eff});
  assign f_take  = fv_r && !vis_q && ((chosen_r == '0) || (dist_q < best_r));

  always_comb begin
    rs_x = (rs_r == '0) ? VAL_W'(1) : rs_r;
    rs_x = rs_x ^ (rs_x << 13);
    rs_x = rs_x ^ (rs_x >> 17);
    rs_nxt = rs_x ^ (rs_x << 5);
  end

  always_comb begin
    cand_we = in_acc && (action_t'(in_tuser) == ACT_LOAD_CAND)
              && (32'(in_row) <= MAX_NODES) && (32'(in_slot) < CAND_SLOTS);
    cand_wa = CA'(32'(in_row) * CAND_SLOTS + 32'(in_slot));
    cand_ra = base_r + CA'(iss_r);
    dist_we = in_acc && (action_t'(in_tuser) == ACT_LOAD_DIST)
              && (32'(in_row) <= MAX_NODES) && (32'(in_node) <= MAX_NODES);
    dist_wa = DA'(32'(in_row) * ROWS + 32'(in_node));
    dist_ra = dbase_r + DA'(v_r);
    vis_we  = (state_r == ST_CLEAR) || (state_r == ST_MARK);
    vis_wd  = (state_r == ST_MARK);
    vis_wa  = (state_r == ST_MARK) ? RW'(chosen_r) : clr_r;
    vis_ra  = (state_r == ST_FALL) ? RW'(v_r) : RW'(cand_q[NODE_W+VAL_W-1:VAL_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      is_start_r   <= 1'b0;
      rs_r         <= VAL_W'(1);
      node_count_r <= NODE_W'(127);
      cand_use_r   <= 5'd16;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (reg_idx_t'(cfg_addr) == REG_NODE_COUNT) node_count_r <= cfg_wdata;
        else cand_use_r <= cfg_wdata[4:0];
      end
      // drop the word once taken; the finish state refills the register itself
      if (out_tready && (state_r != ST_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + RW'(1);
          if (32'(clr_r) == ROWS - 1) state_r <= is_start_r ? ST_FIN : ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            chosen_r <= '0;
            fell_r   <= 1'b0;
            case (action_t'(in_tuser))
              ACT_START: begin
                clr_r      <= '0;
                is_start_r <= 1'b1;
                rs_r       <= (in_seed == '0) ? VAL_W'(1) : in_seed;
                state_r    <= ST_CLEAR;
              end
              ACT_SELECT: begin
                base_r  <= CA'(32'(in_row) * CAND_SLOTS);
                dbase_r <= DA'(32'(in_row) * ROWS);
                sum_r   <= '0;
                run_r   <= '0;
                found_r <= 1'b0;
                last_r  <= '0;
                iss_r   <= '0;
                p1_r    <= 1'b0;
                p2_r    <= 1'b0;
                state_r <= (32'(in_row) <= MAX_NODES) ? ST_SUM : ST_FIN;
              end
              default: state_r <= ST_FIN;
            endcase
          end
        end
        ST_SUM, ST_PICK: begin
          if (issue) iss_r <= iss_r + KW'(1);
          p1_r      <= issue;
          p2_r      <= p1_r;
          p2_node_r <= cand_q[NODE_W+VAL_W-1:VAL_W];
          p2_w_r    <= cand_q[VAL_W-1:0];
          if (state_r == ST_SUM) begin
            if (elig) sum_r <= sum_r + SW'(p2_w_r);
            if (!issue && !p1_r && !p2_r) begin
              iss_r <= '0;
              if (sum_r == '0) begin
                v_r     <= (NODE_W+1)'(1);
                fv_r    <= 1'b0;
                state_r <= ST_FALL;
              end else begin
                state_r <= ST_THR1;
              end
            end
          end else begin
            if (elig && (p2_w_r != '0) && !found_r) begin
              run_r  <= run_nxt;
              last_r <= p2_node_r;
              if (run_nxt >= thr_r) found_r <= 1'b1;
            end
            if (!issue && !p1_r && !p2_r) begin
              chosen_r <= last_r;
              v_r      <= (NODE_W+1)'(1);
              fv_r     <= 1'b0;
              state_r  <= (last_r == '0) ? ST_FALL : ST_MARK;
            end
          end
        end
        ST_THR1: begin
          rs_r      <= rs_nxt;
          prod_lo_r <= rs_nxt * sum_r[VAL_W-1:0];
          prod_hi_r <= SW'(64'(rs_nxt) * 64'(sum_r[SW-1:VAL_W]));
          state_r   <= ST_THR2;
        end
        ST_THR2: begin
          thr_r   <= prod_hi_r + SW'(prod_lo_r[63:32]);
          state_r <= ST_PICK;
        end
        ST_FALL: begin
          if (f_issue) v_r <= v_r + (NODE_W+1)'(1);
          fv_r      <= f_issue;
          fv_node_r <= v_r[NODE_W-1:0];
          if (f_take) begin
            chosen_r <= fv_node_r;
            best_r   <= dist_q;
          end
          if (!f_issue && !fv_r) begin
            fell_r  <= (chosen_r != '0);
            state_r <= (chosen_r != '0) ? ST_MARK : ST_FIN;
          end
        end
        ST_MARK: state_r <= ST_FIN;
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_node_r  <= chosen_r;
            out_fb_r    <= fell_r;
            is_start_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_node_r);
  assign out_tuser  = out_fb_r;

  `RNS_ASSERT_NOW(a_fb_nonzero, out_tvalid && out_tuser, out_tdata != '0)
  `RNS_ASSERT_NOW(a_mark_nonzero, state_r == ST_MARK, chosen_r != '0)
  `RNS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  `RNS_ASSERT_NOW(a_thr_below_sum, state_r == ST_PICK, thr_r < sum_r)

endmodule
